// ----- src/box_blur_3x3_top_defines.svh -----
// Assertion macros for the box blur block.
// Needs aclk and aresetn in scope where a macro is used.
`ifndef BOX_BLUR_3X3_TOP_DEFINES_SVH
`define BOX_BLUR_3X3_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BB3_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BB3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/bb3_pkg.sv -----
// Shared types and constants for the 3x3 box blur.
// No dependencies.
package bb3_pkg;

    localparam int PIX_W       = 8;
    localparam int ROW_W       = 12;
    localparam int COL_W       = 10;
    localparam int CFG_W       = 13;
    localparam int HEIGHT_W    = 13;
    localparam int WIDTH_W     = 11;
    localparam int SUM_W       = 12;
    localparam int DIV_W       = 4;
    localparam int RECIP_W     = 16;
    localparam int RECIP_SHIFT = 15;
    localparam int NUM_RES     = 4;

    localparam logic CFG_HEIGHT = 1'b0;
    localparam logic CFG_WIDTH  = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } pixel_t;

    localparam int PIXEL_BITS = $bits(pixel_t);

    // [row][col], row 2 and col 2 are the newest
    typedef pixel_t [2:0][2:0] window_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             done;
    } meta_t;

    typedef struct packed {
        logic [2:0] rows;
        logic [2:0] cols;
        meta_t      meta;
    } avg_req_t;

    // ceil(2^15 / n); exact for every rounded sum a 3x3 window can give
    function automatic logic [RECIP_W-1:0] recip(input logic [DIV_W-1:0] n);
        logic [RECIP_W-1:0] m;
        begin
            case (n)
                4'd1:    m = 16'd32768;
                4'd2:    m = 16'd16384;
                4'd3:    m = 16'd10923;
                4'd4:    m = 16'd8192;
                4'd6:    m = 16'd5462;
                4'd9:    m = 16'd3641;
                default: m = 16'd32768;
            endcase
            return m;
        end
    endfunction

endpackage

// ----- src/bb3_avg.sv -----
// Masked 3x3 window sum and rounded division by the neighbour count.
// Two registered stages with valid/ready; depends on bb3_pkg.
module bb3_avg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    output logic              req_ready,
    input  bb3_pkg::window_t  win,
    input  bb3_pkg::avg_req_t req,
    output logic              res_valid,
    input  logic              res_ready,
    output bb3_pkg::pixel_t   res_pix,
    output bb3_pkg::meta_t    res_meta
);

    localparam int PROD_W = bb3_pkg::SUM_W + bb3_pkg::RECIP_W;

    logic [bb3_pkg::SUM_W-1:0]   sum_r, sum_g, sum_b;
    logic [1:0]                  nr, nc;
    logic [bb3_pkg::DIV_W-1:0]   n, half;

    logic                        a_valid_reg;
    logic [bb3_pkg::SUM_W-1:0]   a_red_reg, a_green_reg, a_blue_reg;
    logic [bb3_pkg::RECIP_W-1:0] a_recip_reg;
    bb3_pkg::meta_t              a_meta_reg;

    logic                        b_valid_reg;
    bb3_pkg::pixel_t             b_pix_reg;
    bb3_pkg::meta_t              b_meta_reg;

    logic                        b_take, a_ready;
    logic [PROD_W-1:0]           prod_r, prod_g, prod_b;

    always_comb begin
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                if (req.rows[a] && req.cols[b]) begin
                    sum_r = sum_r + bb3_pkg::SUM_W'(win[a][b].red);
                    sum_g = sum_g + bb3_pkg::SUM_W'(win[a][b].green);
                    sum_b = sum_b + bb3_pkg::SUM_W'(win[a][b].blue);
                end
            end
        end
        nr   = 2'($countones(req.rows));
        nc   = 2'($countones(req.cols));
        n    = bb3_pkg::DIV_W'(nr) * bb3_pkg::DIV_W'(nc);
        half = n >> 1;
    end

    assign b_take    = !b_valid_reg || res_ready;
    assign a_ready   = !a_valid_reg || b_take;
    assign req_ready = a_ready;

    // round half up, then divide by multiplying with the reciprocal
    assign prod_r = PROD_W'(a_red_reg) * PROD_W'(a_recip_reg);
    assign prod_g = PROD_W'(a_green_reg) * PROD_W'(a_recip_reg);
    assign prod_b = PROD_W'(a_blue_reg) * PROD_W'(a_recip_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= req_valid;
            end
            if (b_take) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && req_valid) begin
            a_red_reg   <= sum_r + bb3_pkg::SUM_W'(half);
            a_green_reg <= sum_g + bb3_pkg::SUM_W'(half);
            a_blue_reg  <= sum_b + bb3_pkg::SUM_W'(half);
            a_recip_reg <= bb3_pkg::recip(n);
            a_meta_reg  <= req.meta;
        end
        if (b_take && a_valid_reg) begin
            b_pix_reg.red   <= prod_r[bb3_pkg::RECIP_SHIFT +: bb3_pkg::PIX_W];
            b_pix_reg.green <= prod_g[bb3_pkg::RECIP_SHIFT +: bb3_pkg::PIX_W];
            b_pix_reg.blue  <= prod_b[bb3_pkg::RECIP_SHIFT +: bb3_pkg::PIX_W];
            b_meta_reg      <= a_meta_reg;
        end
    end

    assign res_valid = b_valid_reg;
    assign res_pix   = b_pix_reg;
    assign res_meta  = b_meta_reg;

endmodule

// ----- src/box_blur_3x3_top.sv -----
// 3x3 box blur top level: line buffer memory, window, result sequencer.
// Flow: the line buffer is a single-port read-modify-write: read on accept in IDLE,
// written in LOAD. Then the pixel's results (0..4) issue in EMIT, one per cycle while
// the averaging pipeline is ready. A new pixel is taken only in IDLE.
// Reset: counters cleared, height and width set to 1; line buffer is not cleared.
// Depends on bb3_pkg, bb3_avg and box_blur_3x3_top_defines.svh.
`include "box_blur_3x3_top_defines.svh"

module box_blur_3x3_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bb3_pkg::PIX_W-1:0]     s_red_in,
    input  logic [bb3_pkg::PIX_W-1:0]     s_green_in,
    input  logic [bb3_pkg::PIX_W-1:0]     s_blue_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bb3_pkg::PIX_W-1:0]     m_red_out,
    output logic [bb3_pkg::PIX_W-1:0]     m_green_out,
    output logic [bb3_pkg::PIX_W-1:0]     m_blue_out,
    output logic [bb3_pkg::ROW_W-1:0]     m_out_row,
    output logic [bb3_pkg::COL_W-1:0]     m_out_col,
    output logic                          m_frame_done,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_index,
    input  logic [bb3_pkg::CFG_W-1:0]     cfg_wr_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PB = bb3_pkg::PIXEL_BITS;
    localparam int NR = bb3_pkg::NUM_RES;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [HW-1:0]          height_reg;
    logic [WW-1:0]          width_reg;
    logic [HW-1:0]          h_clamped;
    logic [WW-1:0]          w_clamped;
    logic [bb3_pkg::HEIGHT_W-1:0] h_field;
    logic [bb3_pkg::WIDTH_W-1:0]  w_field;

    logic [RW-1:0]          row_count_reg;
    logic [AW-1:0]          col_count_reg;
    logic [RW-1:0]          r_cur_reg;
    logic [AW-1:0]          c_cur_reg;
    logic [NR-1:0]          pend_reg, pend_next;
    logic [2:0]             up_rows_reg, last_rows_reg, col_cols_reg, edge_cols_reg;
    bb3_pkg::pixel_t        px_reg;
    bb3_pkg::window_t       win_reg;

    logic [2*PB-1:0]        lbuf_mem [MAX_WIDTH];
    logic [2*PB-1:0]        rd_data_reg;

    logic                   accept;
    logic                   right, last_row, r_ge1, r_ge2, c_ge1, c_ge2;
    logic [RW-1:0]          r_prev;
    logic [AW-1:0]          c_prev;

    logic                   req_valid, req_ready;
    bb3_pkg::avg_req_t      req;
    bb3_pkg::pixel_t        res_pix;
    bb3_pkg::meta_t         res_meta;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // out-of-range sizes: zero acts as one, above the maximum saturates
    always_comb begin
        h_field = cfg_wr_data[bb3_pkg::HEIGHT_W-1:0];
        w_field = cfg_wr_data[bb3_pkg::WIDTH_W-1:0];
        if (h_field == '0) begin
            h_clamped = HW'(1);
        end else if (32'(h_field) > MAX_HEIGHT) begin
            h_clamped = HW'(MAX_HEIGHT);
        end else begin
            h_clamped = HW'(h_field);
        end
        if (w_field == '0) begin
            w_clamped = WW'(1);
        end else if (32'(w_field) > MAX_WIDTH) begin
            w_clamped = WW'(MAX_WIDTH);
        end else begin
            w_clamped = WW'(w_field);
        end
    end

    assign right    = (WW'(col_count_reg) + WW'(1)) >= width_reg;
    assign last_row = (HW'(row_count_reg) + HW'(1)) >= height_reg;
    assign r_ge1    = (32'(row_count_reg) >= 1);
    assign r_ge2    = (32'(row_count_reg) >= 2);
    assign c_ge1    = (32'(col_count_reg) >= 1);
    assign c_ge2    = (32'(col_count_reg) >= 2);

    assign r_prev = r_cur_reg - RW'(1);
    assign c_prev = c_cur_reg - AW'(1);

    // pick the lowest pending result; order is up-left, up-edge, last-left, last-edge
    always_comb begin
        req.rows      = up_rows_reg;
        req.cols      = col_cols_reg;
        req.meta.row  = bb3_pkg::ROW_W'(r_prev);
        req.meta.col  = bb3_pkg::COL_W'(c_prev);
        req.meta.done = 1'b0;
        pend_next     = pend_reg;
        if (pend_reg[0]) begin
            pend_next[0] = 1'b0;
        end else if (pend_reg[1]) begin
            req.cols     = edge_cols_reg;
            req.meta.col = bb3_pkg::COL_W'(c_cur_reg);
            pend_next[1] = 1'b0;
        end else if (pend_reg[2]) begin
            req.rows     = last_rows_reg;
            req.meta.row = bb3_pkg::ROW_W'(r_cur_reg);
            pend_next[2] = 1'b0;
        end else begin
            req.rows      = last_rows_reg;
            req.cols      = edge_cols_reg;
            req.meta.row  = bb3_pkg::ROW_W'(r_cur_reg);
            req.meta.col  = bb3_pkg::COL_W'(c_cur_reg);
            req.meta.done = 1'b1;
            pend_next[3]  = 1'b0;
        end
    end

    assign req_valid = (state_reg == ST_EMIT);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = (pend_reg == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (req_ready && pend_next == '0) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            height_reg    <= HW'(1);
            width_reg     <= WW'(1);
            row_count_reg <= '0;
            col_count_reg <= '0;
            pend_reg      <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                // any size write restarts the frame
                if (cfg_index == bb3_pkg::CFG_HEIGHT) begin
                    height_reg <= h_clamped;
                end else begin
                    width_reg <= w_clamped;
                end
                row_count_reg <= '0;
                col_count_reg <= '0;
            end else if (accept) begin
                pend_reg <= {last_row && right, last_row && c_ge1, r_ge1 && right, r_ge1 && c_ge1};
                if (right) begin
                    col_count_reg <= '0;
                    row_count_reg <= last_row ? '0 : row_count_reg + RW'(1);
                end else begin
                    col_count_reg <= col_count_reg + AW'(1);
                end
            end else if (state_reg == ST_EMIT && req_ready) begin
                pend_reg <= pend_next;
            end
        end
    end

    // hold the beat's pixel, its position and window masks
    always_ff @(posedge aclk) begin
        if (accept) begin
            px_reg        <= '{red: s_red_in, green: s_green_in, blue: s_blue_in};
            r_cur_reg     <= row_count_reg;
            c_cur_reg     <= col_count_reg;
            up_rows_reg   <= r_ge2 ? 3'b111 : 3'b110;
            last_rows_reg <= r_ge1 ? 3'b110 : 3'b100;
            col_cols_reg  <= c_ge2 ? 3'b111 : 3'b110;
            edge_cols_reg <= c_ge1 ? 3'b110 : 3'b100;
        end
        if (state_reg == ST_LOAD) begin
            for (int k = 0; k < 3; k++) begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= win_reg[k][2];
            end
            win_reg[0][2] <= bb3_pkg::pixel_t'(rd_data_reg[2*PB-1:PB]);
            win_reg[1][2] <= bb3_pkg::pixel_t'(rd_data_reg[PB-1:0]);
            win_reg[2][2] <= px_reg;
        end
    end

    // line buffer: upper half two rows back, lower half one row back
    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= lbuf_mem[col_count_reg];
        end
        if (state_reg == ST_LOAD) begin
            lbuf_mem[c_cur_reg] <= {rd_data_reg[PB-1:0], px_reg};
        end
    end

    bb3_avg u_avg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .win       (win_reg),
        .req       (req),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res_pix   (res_pix),
        .res_meta  (res_meta)
    );

    assign m_red_out    = res_pix.red;
    assign m_green_out  = res_pix.green;
    assign m_blue_out   = res_pix.blue;
    assign m_out_row    = res_meta.row;
    assign m_out_col    = res_meta.col;
    assign m_frame_done = res_meta.done;

    `BB3_ASSERT_NOW(a_idle_no_pending, s_ready, pend_reg == '0, "pixel taken with results pending")
    `BB3_ASSERT_NEXT(a_accept_loads, s_valid && s_ready, state_reg == ST_LOAD, "accept did not load")
    `BB3_ASSERT_NOW(a_emit_has_work, state_reg == ST_EMIT, pend_reg != '0, "emit with nothing pending")
    `BB3_ASSERT_NOW(a_col_in_range, 1'b1, WW'(col_count_reg) < width_reg, "column past width")
    `BB3_ASSERT_NOW(a_row_in_range, 1'b1, HW'(row_count_reg) < height_reg, "row past height")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for box_blur_3x3_top: streams RGB beats over many frame sizes,
// predicts every blurred pixel in a scoreboard class and checks each result beat.
// Depends on bb3_pkg and the box_blur_3x3_top RTL.
module tb_top;

    localparam int LINE_MAX    = 1024;
    localparam int ROWS_MAX    = 4096;
    localparam int RAND_PIXELS = 280;
    localparam int SETTLE_CYC  = 16;
    localparam int IDLE_PCT    = 14;

    localparam bb3_pkg::pixel_t DEMO_PIXELS [16] = '{
        24'hFFFFFF, 24'h000000, 24'hFF00FF, 24'h010203, 24'hFFFFFF,
        24'h7F8081, 24'h000000, 24'hFEFEFE, 24'h123456,
        24'hFF0080, 24'h01FF7F, 24'h000000, 24'hFFFFFF,
        24'h00FF01, 24'hFF00FE, 24'h808080
    };

    typedef struct packed {
        bb3_pkg::pixel_t px;
        bb3_pkg::meta_t  meta;
    } blurred_t;

    class blur_board;
        int unsigned     rows_cfg;
        int unsigned     cols_cfg;
        int unsigned     cur_row;
        int unsigned     cur_col;
        bb3_pkg::pixel_t line_mem [2][LINE_MAX];
        bb3_pkg::pixel_t win [3][3];
        blurred_t        pending [$];
        int unsigned     errors;

        function new();
            foreach (line_mem[i, j]) line_mem[i][j] = '0;
            rows_cfg = 1;
            cols_cfg = 1;
            errors = 0;
            restart();
        endfunction

        function void restart();
            foreach (win[i, j]) win[i][j] = '0;
            cur_row = 0;
            cur_col = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned maxv);
            if (v == 0) return 1;
            if (v > maxv) return maxv;
            return v;
        endfunction

        // any write restarts the frame
        function void write_reg(logic idx, logic [bb3_pkg::CFG_W-1:0] data);
            if (idx == bb3_pkg::CFG_HEIGHT)
                rows_cfg = clamp_size(32'(data[bb3_pkg::HEIGHT_W-1:0]), ROWS_MAX);
            else
                cols_cfg = clamp_size(32'(data[bb3_pkg::WIDTH_W-1:0]), LINE_MAX);
            restart();
        endfunction

        // average window rows lo_r..2 and columns lo_c..2, rounding halves up
        function void push_average(int unsigned lo_r, int unsigned lo_c,
                                   int unsigned row, int unsigned col, bit done);
            int unsigned sr, sg, sb, n;
            blurred_t res;
            sr = 0;
            sg = 0;
            sb = 0;
            for (int a = lo_r; a < 3; a++) begin
                for (int b = lo_c; b < 3; b++) begin
                    sr += 32'(win[a][b].red);
                    sg += 32'(win[a][b].green);
                    sb += 32'(win[a][b].blue);
                end
            end
            n = (3 - lo_r) * (3 - lo_c);
            res.px.red    = bb3_pkg::PIX_W'((sr + n / 2) / n);
            res.px.green  = bb3_pkg::PIX_W'((sg + n / 2) / n);
            res.px.blue   = bb3_pkg::PIX_W'((sb + n / 2) / n);
            res.meta.row  = bb3_pkg::ROW_W'(row);
            res.meta.col  = bb3_pkg::COL_W'(col);
            res.meta.done = done;
            pending.push_back(res);
        endfunction

        function void note_pixel(bb3_pkg::pixel_t px);
            int unsigned r, c, ci;
            int unsigned up_lo, last_lo, col_lo, edge_lo;
            bit last_row, right_edge;
            r = cur_row;
            c = cur_col;
            ci = (c < LINE_MAX) ? c : LINE_MAX - 1;
            last_row = (r + 1 >= rows_cfg);
            right_edge = (c + 1 >= cols_cfg);

            for (int k = 0; k < 3; k++) begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = line_mem[1][ci];
            win[1][2] = line_mem[0][ci];
            win[2][2] = px;
            line_mem[1][ci] = line_mem[0][ci];
            line_mem[0][ci] = px;

            up_lo   = (r >= 2) ? 0 : 1;
            last_lo = (r >= 1) ? 1 : 2;
            col_lo  = (c >= 2) ? 0 : 1;
            edge_lo = (c >= 1) ? 1 : 2;

            if (r >= 1) begin
                if (c >= 1) push_average(up_lo, col_lo, r - 1, c - 1, 1'b0);
                if (right_edge) push_average(up_lo, edge_lo, r - 1, c, 1'b0);
            end
            if (last_row) begin
                if (c >= 1) push_average(last_lo, col_lo, r, c - 1, 1'b0);
                if (right_edge) push_average(last_lo, edge_lo, r, c, 1'b1);
            end

            if (right_edge) begin
                cur_col = 0;
                cur_row = last_row ? 0 : r + 1;
            end else begin
                cur_col = c + 1;
            end
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(blurred_t got);
            blurred_t want;
            if (pending.size() == 0) begin
                $display("%0t: result beat row %0d col %0d with nothing expected",
                         $time, got.meta.row, got.meta.col);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("red", 16'(want.px.red), 16'(got.px.red));
            compare_field("green", 16'(want.px.green), 16'(got.px.green));
            compare_field("blue", 16'(want.px.blue), 16'(got.px.blue));
            compare_field("row", 16'(want.meta.row), 16'(got.meta.row));
            compare_field("col", 16'(want.meta.col), 16'(got.meta.col));
            compare_field("frame_done", 16'(want.meta.done), 16'(got.meta.done));
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn;
    logic                          s_valid;
    logic                          s_ready;
    logic [bb3_pkg::PIX_W-1:0]     s_red_in;
    logic [bb3_pkg::PIX_W-1:0]     s_green_in;
    logic [bb3_pkg::PIX_W-1:0]     s_blue_in;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [bb3_pkg::PIX_W-1:0]     m_red_out;
    logic [bb3_pkg::PIX_W-1:0]     m_green_out;
    logic [bb3_pkg::PIX_W-1:0]     m_blue_out;
    logic [bb3_pkg::ROW_W-1:0]     m_out_row;
    logic [bb3_pkg::COL_W-1:0]     m_out_col;
    logic                          m_frame_done;
    logic                          cfg_wr_en;
    logic                          cfg_index;
    logic [bb3_pkg::CFG_W-1:0]     cfg_wr_data;

    bit        gaps_on = 1'b1;
    blur_board board = new();

    box_blur_3x3_top #(
        .MAX_WIDTH  (LINE_MAX),
        .MAX_HEIGHT (ROWS_MAX)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_red_in     (s_red_in),
        .s_green_in   (s_green_in),
        .s_blue_in    (s_blue_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_red_out    (m_red_out),
        .m_green_out  (m_green_out),
        .m_blue_out   (m_blue_out),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_done (m_frame_done),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // result side: check each accepted beat, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result({m_red_out, m_green_out, m_blue_out,
                                m_out_row, m_out_col, m_frame_done});
        m_ready <= !gaps_on || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic bb3_pkg::pixel_t random_pixel();
        bb3_pkg::pixel_t px;
        px = bb3_pkg::pixel_t'(bb3_pkg::PIXEL_BITS'($urandom));
        if ($urandom_range(99) < 15) begin
            px.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            px.green = $urandom_range(1) ? 8'hFF : 8'h00;
            px.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        return px;
    endfunction

    // valid stays high across back-to-back beats; it drops only in a gap or a drain
    task automatic send_pixel(input bb3_pkg::pixel_t px);
        if (gaps_on) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid    <= 1'b1;
        s_red_in   <= px.red;
        s_green_in <= px.green;
        s_blue_in  <= px.blue;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_pixel(px);
    endtask

    // hold the input until every expected beat is out, then let the pipeline settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic configure(input logic [bb3_pkg::CFG_W-1:0] h_val,
                             input logic [bb3_pkg::CFG_W-1:0] w_val,
                             input bit set_h, input bit set_w);
        drain_results();
        if (set_h) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= bb3_pkg::CFG_HEIGHT;
            cfg_wr_data <= h_val;
            @(posedge aclk);
            board.write_reg(bb3_pkg::CFG_HEIGHT, h_val);
        end
        if (set_w) begin
            cfg_wr_en   <= 1'b1;
            cfg_index   <= bb3_pkg::CFG_WIDTH;
            cfg_wr_data <= w_val;
            @(posedge aclk);
            board.write_reg(bb3_pkg::CFG_WIDTH, w_val);
        end
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int unsigned                  sent;
        int unsigned                  frame_px;
        int unsigned                  n_frames;
        int unsigned                  pick;
        logic [bb3_pkg::CFG_W-1:0]    h_val;
        logic [bb3_pkg::CFG_W-1:0]    w_val;

        aresetn     <= 1'b0;
        s_valid     <= 1'b0;
        s_red_in    <= '0;
        s_green_in  <= '0;
        s_blue_in   <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_index   <= bb3_pkg::CFG_HEIGHT;
        cfg_wr_data <= '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size is 1x1: each beat is a whole frame
        send_pixel('0);
        send_pixel('1);

        // 3x3: corners, edges and the full interior window
        configure(13'd3, 13'd3, 1'b1, 1'b1);
        for (int i = 0; i < 9; i++) send_pixel(DEMO_PIXELS[i]);

        // height of zero acts as one row
        configure(13'd0, 13'd4, 1'b1, 1'b1);
        for (int i = 9; i < 13; i++) send_pixel(DEMO_PIXELS[i]);

        // width field masks to zero, so one column
        configure(13'd3, 13'h1800, 1'b1, 1'b1);
        for (int i = 13; i < 16; i++) send_pixel(DEMO_PIXELS[i]);

        // oversized values saturate; restart part way through the first row
        configure('1, '1, 1'b1, 1'b1);
        repeat (4) send_pixel(random_pixel());
        configure(13'd1, 13'd1024, 1'b1, 1'b1);
        repeat (4) send_pixel(random_pixel());

        sent = 0;
        while (sent < RAND_PIXELS) begin
            pick  = $urandom_range(99);
            h_val = ($urandom_range(9) == 0) ? '0 : bb3_pkg::CFG_W'($urandom_range(5, 1));
            w_val = ($urandom_range(9) == 0) ? '0 : bb3_pkg::CFG_W'($urandom_range(8, 1));
            if ($urandom_range(4) == 0)
                w_val[bb3_pkg::CFG_W-1:bb3_pkg::WIDTH_W] = 2'($urandom_range(3, 1));
            configure(h_val, w_val, pick < 80, pick >= 20);
            n_frames = $urandom_range(3, 1);
            for (int f = 0; f < n_frames; f++) begin
                frame_px = board.rows_cfg * board.cols_cfg;
                // cut the last frame short now and then; the next write restarts it
                if (f == n_frames - 1 && frame_px > 1 && $urandom_range(4) == 0)
                    frame_px = $urandom_range(frame_px - 1, 1);
                repeat (frame_px) begin
                    gaps_on = (sent < 120 || sent >= 200);
                    send_pixel(random_pixel());
                    sent++;
                    if ($urandom_range(24) == 0) drain_results();
                end
            end
        end

        drain_results();
        if (board.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/bb3_pkg.sv
src/bb3_avg.sv
src/box_blur_3x3_top.sv
tb/tb_top.sv
